>>> hw/rtl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// Used by mme_mac_cell, matrix_multiply_engine_top and tb_top; depends on nothing.
package mme_pkg;

    localparam int IDX_W    = 4;    // width of the row and column index fields
    localparam int IDX_LIMIT = 16;  // sizes the index fields can address
    localparam int SIZE_W   = 5;    // width of the size registers
    localparam int VAL_W    = 16;   // Q8.8 element
    localparam int PROD_W   = 32;   // Q16.16 product of two elements
    localparam int ACC_W    = 36;   // Q20.16 sum of up to sixteen products

    localparam logic [1:0] FN_WR_A = 2'd0;
    localparam logic [1:0] FN_WR_B = 2'd1;
    localparam logic [1:0] FN_EMIT = 2'd2;

    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DRAIN
    } mme_state_t;

    // One step of a dot product as it travels down the cell chain.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] k;
        logic [VAL_W-1:0] a;
    } mme_lane_t;

    // Write of one element of B, offered to every cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] data;
    } mme_bwr_t;

endpackage

>>> hw/rtl/mme_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the A store and each cell's column of B.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mme_mac_cell.sv
// One multiply-accumulate cell of the chain: holds one column of B and its dot product.
// Depends on mme_pkg (lane and write types) and mme_ram.
module mme_mac_cell #(
    parameter int DIM     = 16,
    parameter int CELL_ID = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mme_pkg::mme_bwr_t                   bwr,
    input  logic                                clear,
    input  mme_pkg::mme_lane_t                  lane_in,
    output mme_pkg::mme_lane_t                  lane_out,
    output logic signed [mme_pkg::ACC_W-1:0]    acc,
    output logic                                done
);

    localparam int DIM_W = $clog2(DIM);

    logic                               b_we;
    logic [mme_pkg::VAL_W-1:0]          b_rd;

    mme_pkg::mme_lane_t                 s1_reg;
    logic                               s2_valid_reg;
    logic                               s2_first_reg;
    logic                               s2_last_reg;
    logic signed [mme_pkg::PROD_W-1:0]  prod_reg;
    logic signed [mme_pkg::PROD_W-1:0]  prod_next;
    logic signed [mme_pkg::ACC_W-1:0]   acc_reg;
    logic signed [mme_pkg::ACC_W-1:0]   acc_next;
    logic                               done_reg;
    logic                               done_next;

    assign b_we = bwr.en && (bwr.col == mme_pkg::IDX_W'(CELL_ID));

    // Column CELL_ID of B, addressed by its row.
    mme_ram #(
        .WIDTH (mme_pkg::VAL_W),
        .DEPTH (DIM)
    ) u_b_col (
        .clk   (clk),
        .we    (b_we),
        .waddr (bwr.row[DIM_W-1:0]),
        .wdata (bwr.data),
        .raddr (lane_in.k[DIM_W-1:0]),
        .rdata (b_rd)
    );

    always_comb
    begin
        prod_next = $signed(s1_reg.a) * $signed(b_rd);
        acc_next  = acc_reg;
        if (s2_valid_reg)
        begin
            acc_next = (s2_first_reg ? '0 : acc_reg)
                     + {{(mme_pkg::ACC_W-mme_pkg::PROD_W){prod_reg[mme_pkg::PROD_W-1]}},
                        prod_reg};
        end
        done_next = done_reg;
        if (clear)
        begin
            done_next = 1'b0;
        end
        else if (s2_valid_reg && s2_last_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_reg       <= lane_in;
            s2_valid_reg <= s1_reg.valid;
            s2_first_reg <= s1_reg.first;
            s2_last_reg  <= s1_reg.last;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign lane_out = s1_reg;
    assign acc      = acc_reg;
    assign done     = done_reg;

    a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_reg.valid))
        else $error("product stage valid without a preceding read stage");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(s2_valid_reg && s2_last_reg))
        else $error("cell finished without the last step of its dot product");

    a_no_step_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !done_reg)
        else $error("accumulation step arrived while the result was marked done");

endmodule

>>> hw/rtl/matrix_multiply_engine_top.sv
// Top level of the matrix multiply engine: A store, sequencer, MAC cell chain and output.
// Depends on mme_pkg, mme_ram and mme_mac_cell.
//
// Use: configure rows_a, inner_len and cols_b through cfg_we/cfg_index/cfg_wdata while idle.
// Input items on s_axis carry func in tuser: func 0 writes one element of A, func 1 one
// element of B, func 2 asks for one row of C. A write gives no result.
// An emit walks the inner index through the A store, one element per cycle, and broadcasts
// it down a chain of MAX_DIM cells, at most 16; cell j holds column j of B and accumulates
// C[row][j]. Each element passes one register in each cell as it travels the chain. The
// row is then delivered on m_axis in column order, one item per cycle while the receiver
// is ready, with tlast on the last column. An emit occupies the block until the last
// column of its row is in the output register, and no new items are taken meanwhile.
// If the receiver stalls, the row waits in the cells and the output register holds its
// item; once the last item of a row sits in the output register, new items are taken.
// Reset sets all sizes to 16 and clears the sequencer; the stores are not cleared and
// must be written before they are used.
module matrix_multiply_engine_top #(
    parameter int MAX_DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index[3:0], col_index[7:4], element_value[23:8]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_row[3:0], out_col[7:4], product_value[43:8]
    output logic        m_axis_tlast    // row_last
);

    localparam int DIM   = (MAX_DIM > mme_pkg::IDX_LIMIT) ? mme_pkg::IDX_LIMIT : MAX_DIM;
    localparam int DIM_W = $clog2(DIM);
    localparam int AW    = $clog2(DIM * DIM);
    localparam int SW    = mme_pkg::SIZE_W;
    localparam int IW    = mme_pkg::IDX_W;

    // Configuration
    logic [SW-1:0] rows_a_reg;
    logic [SW-1:0] inner_len_reg;
    logic [SW-1:0] cols_b_reg;
    logic [SW-1:0] nr;
    logic [SW-1:0] nk;
    logic [SW-1:0] nc;

    // Input decode
    logic [1:0]                in_func;
    logic [IW-1:0]             in_row;
    logic [IW-1:0]             in_col;
    logic [mme_pkg::VAL_W-1:0] in_val;
    logic                      in_acc;
    logic                      a_we;
    logic [AW-1:0]             a_waddr;
    logic [AW-1:0]             a_raddr;
    logic [mme_pkg::VAL_W-1:0] a_rd;
    logic                      emit;
    mme_pkg::mme_bwr_t         bwr;

    // Sequencer
    mme_pkg::mme_state_t state_reg;
    mme_pkg::mme_state_t state_next;
    logic [IW-1:0]       row_reg;
    logic [IW-1:0]       k_reg;
    logic [IW-1:0]       col_reg;
    logic                zero_len_reg;
    logic                k_last;
    logic                col_last;
    logic                load;
    logic                issue_valid;
    logic                tok_valid_reg;
    logic                tok_first_reg;
    logic                tok_last_reg;
    logic [IW-1:0]       tok_k_reg;

    // Cell chain
    mme_pkg::mme_lane_t                lane [DIM+1];
    logic signed [mme_pkg::ACC_W-1:0]  cell_acc [DIM];
    logic [DIM-1:0]                    cell_done;
    logic signed [mme_pkg::ACC_W-1:0]  acc_sel;

    // Output register
    logic                              out_valid_reg;
    logic [IW-1:0]                     out_row_reg;
    logic [IW-1:0]                     out_col_reg;
    logic signed [mme_pkg::ACC_W-1:0]  out_val_reg;
    logic                              out_last_reg;

    assign nr = (rows_a_reg    > SW'(DIM)) ? SW'(DIM) : rows_a_reg;
    assign nk = (inner_len_reg > SW'(DIM)) ? SW'(DIM) : inner_len_reg;
    assign nc = (cols_b_reg    > SW'(DIM)) ? SW'(DIM) : cols_b_reg;

    assign in_func = s_axis_tuser;
    assign in_row  = s_axis_tdata[3:0];
    assign in_col  = s_axis_tdata[7:4];
    assign in_val  = s_axis_tdata[23:8];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign a_we = in_acc && (in_func == mme_pkg::FN_WR_A)
               && ({1'b0, in_row} < nr) && ({1'b0, in_col} < nk);
    assign emit = in_acc && (in_func == mme_pkg::FN_EMIT)
               && ({1'b0, in_row} < nr) && (nc != '0);

    assign bwr.en   = in_acc && (in_func == mme_pkg::FN_WR_B)
                   && ({1'b0, in_row} < nk) && ({1'b0, in_col} < nc);
    assign bwr.row  = in_row;
    assign bwr.col  = in_col;
    assign bwr.data = in_val;

    assign a_waddr = AW'(in_row[DIM_W-1:0]) * AW'(DIM) + AW'(in_col[DIM_W-1:0]);
    assign a_raddr = AW'(row_reg[DIM_W-1:0]) * AW'(DIM) + AW'(k_reg[DIM_W-1:0]);

    mme_ram #(
        .WIDTH (mme_pkg::VAL_W),
        .DEPTH (DIM * DIM)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (in_val),
        .raddr (a_raddr),
        .rdata (a_rd)
    );

    assign k_last   = ({1'b0, k_reg} + SW'(1)) == nk;
    assign col_last = ({1'b0, col_reg} + SW'(1)) == nc;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = (nk == '0) ? mme_pkg::ST_DRAIN : mme_pkg::ST_ISSUE;
                end
            end
            mme_pkg::ST_ISSUE:
            begin
                if (k_last)
                begin
                    state_next = mme_pkg::ST_WAIT;
                end
            end
            mme_pkg::ST_WAIT:
            begin
                if (cell_done[DIM-1])
                begin
                    state_next = mme_pkg::ST_DRAIN;
                end
            end
            mme_pkg::ST_DRAIN:
            begin
                if (load && col_last)
                begin
                    state_next = mme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mme_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue_valid   = 1'b0;
        load          = 1'b0;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            mme_pkg::ST_ISSUE:
            begin
                issue_valid = 1'b1;
            end
            mme_pkg::ST_WAIT:
            begin
                issue_valid = 1'b0;
            end
            mme_pkg::ST_DRAIN:
            begin
                load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mme_pkg::ST_IDLE;
            rows_a_reg    <= SW'(16);
            inner_len_reg <= SW'(16);
            cols_b_reg    <= SW'(16);
            k_reg         <= '0;
            col_reg       <= '0;
            tok_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mme_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                    mme_pkg::CFG_INNER_LEN: inner_len_reg <= cfg_wdata;
                    mme_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_wdata;
                    default:                rows_a_reg    <= rows_a_reg;
                endcase
            end
            if (emit)
            begin
                k_reg   <= '0;
                col_reg <= '0;
            end
            else
            begin
                if (issue_valid)
                begin
                    k_reg <= k_reg + IW'(1);
                end
                if (load)
                begin
                    col_reg <= col_reg + IW'(1);
                end
            end
            tok_valid_reg <= issue_valid;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row_reg      <= in_row;
            zero_len_reg <= (nk == '0);
        end
        tok_first_reg <= (k_reg == '0);
        tok_last_reg  <= k_last;
        tok_k_reg     <= k_reg;
        if (load)
        begin
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_val_reg  <= zero_len_reg ? '0 : acc_sel;
            out_last_reg <= col_last;
        end
    end

    // The A element arrives from the store together with its step token.
    assign lane[0].valid = tok_valid_reg;
    assign lane[0].first = tok_first_reg;
    assign lane[0].last  = tok_last_reg;
    assign lane[0].k     = tok_k_reg;
    assign lane[0].a     = a_rd;

    for (genvar j = 0; j < DIM; j++)
    begin : g_cell
        mme_mac_cell #(
            .DIM     (DIM),
            .CELL_ID (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bwr      (bwr),
            .clear    (emit),
            .lane_in  (lane[j]),
            .lane_out (lane[j+1]),
            .acc      (cell_acc[j]),
            .done     (cell_done[j])
        );
    end

    assign acc_sel = cell_acc[col_reg[DIM_W-1:0]];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_val_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    a_drain_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mme_pkg::ST_DRAIN) |-> (zero_len_reg || (&cell_done)))
        else $error("draining a row before every cell has finished");

    a_last_on_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (({1'b0, out_col_reg} + SW'(1)) == nc))
        else $error("row end flagged on a column other than the last");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mme_pkg::ST_ISSUE) |-> ({1'b0, k_reg} < nk))
        else $error("inner index issued beyond inner_len");

    a_chain_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lane[DIM].valid |-> ((state_reg == mme_pkg::ST_ISSUE)
                          || (state_reg == mme_pkg::ST_WAIT)))
        else $error("step still in the cell chain outside a computation");

endmodule

>>> verif/tb_top.sv
// Self-checking bench for matrix_multiply_engine_top: loads A and B, asks for rows of C and
// compares each streamed dot product with a predictor kept inside the bench.
// Depends on mme_pkg and the engine RTL only.
module tb_top;
    import mme_pkg::*;

    localparam int MAX_DIM       = 16;
    localparam int IDLE_PCT      = 9;
    localparam int STALL_LEN     = 300;
    localparam int SETTLE_CYCLES = 80;
    localparam int LIMIT_CYCLES  = 200000;

    localparam logic [1:0] FN_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ACC_W-1:0] prod;
        logic             last;
    } c_elem_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // row_index[3:0], col_index[7:4], element_value[23:8]
    logic [1:0]  s_axis_tuser;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;   // out_row[3:0], out_col[7:4], product_value[43:8]
    logic        m_axis_tlast;   // row_last

    // Predictor copy of the stores and the size registers.
    logic signed [VAL_W-1:0] a_mem [0:MAX_DIM*MAX_DIM-1];
    logic signed [VAL_W-1:0] b_mem [0:MAX_DIM*MAX_DIM-1];
    logic [SIZE_W-1:0] sz_rows  = 5'd16;
    logic [SIZE_W-1:0] sz_inner = 5'd16;
    logic [SIZE_W-1:0] sz_cols  = 5'd16;
    c_elem_t c_expected[$];

    int  fail_count      = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  size_settings   = 0;
    int  cycle_count     = 0;
    int  stall_cnt       = 0;
    bit  stall_req       = 1'b0;
    bit  steady          = 1'b0;

    matrix_multiply_engine_top #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [SIZE_W-1:0] r);
        int s;
        s = r;
        if (s > MAX_DIM)
            s = MAX_DIM;
        if (s > IDX_LIMIT)
            s = IDX_LIMIT;
        return s;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Applies one accepted item to the predictor and queues the row of C it asks for.
    task automatic model_item(input logic [1:0] fn, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
        int      nr;
        int      nk;
        int      nc;
        longint  acc;
        longint  x;
        longint  y;
        c_elem_t e;
        nr = eff_dim(sz_rows);
        nk = eff_dim(sz_inner);
        nc = eff_dim(sz_cols);
        case (fn)
            FN_WR_A:
                if (row < nr && col < nk)
                    a_mem[row * MAX_DIM + col] = val;
            FN_WR_B:
                if (row < nk && col < nc)
                    b_mem[row * MAX_DIM + col] = val;
            FN_EMIT:
                if (row < nr)
                    for (int j = 0; j < nc; j++)
                    begin
                        acc = 0;
                        for (int k = 0; k < nk; k++)
                        begin
                            x = a_mem[row * MAX_DIM + k];
                            y = b_mem[k * MAX_DIM + j];
                            acc += x * y;
                        end
                        e.row  = row;
                        e.col  = IDX_W'(j);
                        e.prod = acc[ACC_W-1:0];
                        e.last = (j == nc - 1);
                        c_expected.push_back(e);
                    end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the item was taken.
    // tvalid is left high so a following item can go out without a gap.
    task automatic send_item(input logic [1:0] fn, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, col, row};
        s_axis_tuser  <= fn;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        model_item(fn, row, col, val);
        items_sent++;
        @(negedge clk);
    endtask

    // Drops tvalid and waits until every row of C has come out and the engine is quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (c_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ROWS_A:    sz_rows  = val;
            CFG_INNER_LEN: sz_inner = val;
            CFG_COLS_B:    sz_cols  = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] k,
                             input logic [SIZE_W-1:0] c, input bit poke_unused = 1'b0);
        settle();
        cfg_write(CFG_ROWS_A, r);
        cfg_write(CFG_INNER_LEN, k);
        cfg_write(CFG_COLS_B, c);
        if (poke_unused)
            cfg_write(CFG_UNUSED, 5'h1F);
        cfg_we <= 1'b0;
        size_settings++;
    endtask

    task automatic flag_field(input string what, input logic [ACC_W-1:0] want,
                              input logic [ACC_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
        end
    endtask

    // Rows 14 and 15 of A and columns 14 and 15 of B hold the extreme values, so the
    // largest and smallest possible dot products are reachable later.
    task automatic load_matrices();
        for (int i = 0; i < MAX_DIM; i++)
            for (int j = 0; j < MAX_DIM; j++)
                send_item(FN_WR_A, IDX_W'(i), IDX_W'(j),
                          (i == 15) ? 16'h8000 : (i == 14) ? 16'h7FFF : pick_value());
        for (int i = 0; i < MAX_DIM; i++)
            for (int j = 0; j < MAX_DIM; j++)
                send_item(FN_WR_B, IDX_W'(i), IDX_W'(j),
                          (j == 15) ? 16'h8000 : (j == 14) ? 16'h7FFF : pick_value());
    endtask

    task automatic test_extremes();
        send_item(FN_EMIT, 4'd15, 4'd0, 16'h0000);
        send_item(FN_EMIT, 4'd14, 4'd0, 16'h0000);
        send_item(FN_WR_A, 4'd0, 4'd0, 16'h8000);
        send_item(FN_WR_B, 4'd0, 4'd0, 16'h7FFF);
        send_item(FN_WR_A, 4'd0, 4'd15, 16'hFFFF);
        send_item(FN_WR_B, 4'd15, 4'd0, 16'h0001);
        send_item(FN_EMIT, 4'd0, 4'd15, 16'hFFFF);
    endtask

    task automatic test_ignored_items();
        set_sizes(5'd3, 5'd4, 5'd5, 1'b1);
        send_item(FN_UNUSED, 4'd1, 4'd1, pick_value());
        send_item(FN_WR_A, 4'd3, 4'd0, pick_value());
        send_item(FN_WR_A, 4'd2, 4'd4, pick_value());
        send_item(FN_WR_B, 4'd4, 4'd0, pick_value());
        send_item(FN_WR_B, 4'd0, 4'd5, pick_value());
        send_item(FN_EMIT, 4'd3, 4'd0, 16'h0000);
        send_item(FN_EMIT, 4'd15, 4'd0, 16'h0000);
        send_item(FN_EMIT, 4'd2, 4'd0, 16'h0000);
        // Sizes above sixteen act as sixteen.
        set_sizes(5'd31, 5'd31, 5'd31);
        send_item(FN_EMIT, 4'd3, 4'd0, 16'h0000);
        send_item(FN_EMIT, 4'd15, 4'd0, 16'h0000);
    endtask

    task automatic test_zero_sizes();
        set_sizes(5'd0, 5'd16, 5'd16);
        send_item(FN_WR_A, 4'd0, 4'd0, pick_value());
        send_item(FN_EMIT, 4'd0, 4'd0, 16'h0000);
        // No inner length: a full row of zeros.
        set_sizes(5'd16, 5'd0, 5'd16);
        send_item(FN_WR_A, 4'd1, 4'd1, pick_value());
        send_item(FN_WR_B, 4'd0, 4'd0, pick_value());
        send_item(FN_EMIT, 4'd1, 4'd0, 16'h0000);
        set_sizes(5'd16, 5'd16, 5'd0);
        send_item(FN_WR_B, 4'd2, 4'd2, pick_value());
        send_item(FN_EMIT, 4'd2, 4'd0, 16'h0000);
        // The ignored writes above must have left the stores alone.
        set_sizes(5'd16, 5'd16, 5'd16);
        send_item(FN_EMIT, 4'd0, 4'd0, 16'h0000);
        send_item(FN_EMIT, 4'd1, 4'd0, 16'h0000);
        send_item(FN_EMIT, 4'd2, 4'd0, 16'h0000);
    endtask

    task automatic test_smallest_sizes();
        set_sizes(5'd1, 5'd1, 5'd1);
        send_item(FN_WR_A, 4'd0, 4'd0, 16'hFFFF);
        send_item(FN_WR_B, 4'd0, 4'd0, 16'h8000);
        send_item(FN_WR_A, 4'd0, 4'd1, pick_value());
        send_item(FN_EMIT, 4'd0, 4'd0, 16'h0000);
        send_item(FN_EMIT, 4'd1, 4'd0, 16'h0000);
    endtask

    // The receiver holds off while several rows are requested, so the engine must
    // stop taking items until the output drains.
    task automatic test_backpressure();
        set_sizes(5'd16, 5'd16, 5'd16);
        stall_req <= 1'b1;
        repeat (5)
            send_item(FN_EMIT, IDX_W'($urandom_range(15)), IDX_W'($urandom), 16'h0000);
        stall_req <= 1'b0;
    endtask

    task automatic test_random();
        logic [SIZE_W-1:0] sz [3];
        int nr;
        int nk;
        int nc;
        int roll;
        for (int phase = 0; phase < 8; phase++)
        begin
            for (int i = 0; i < 3; i++)
                sz[i] = ($urandom_range(7) == 0) ? SIZE_W'($urandom_range(31, 17))
                                                 : SIZE_W'($urandom_range(16, 1));
            if (phase == 0)
                sz = '{5'd16, 5'd16, 5'd16};
            else if (phase == 1)
                sz = '{5'd1, 5'd1, 5'd16};
            set_sizes(sz[0], sz[1], sz[2]);
            steady <= (phase == 3);
            nr = eff_dim(sz[0]);
            nk = eff_dim(sz[1]);
            nc = eff_dim(sz[2]);
            repeat (32)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    send_item(2'($urandom), IDX_W'($urandom), IDX_W'($urandom), pick_value());
                else if (roll < 40)
                    send_item(FN_WR_A, IDX_W'($urandom_range(nr - 1, 0)),
                              IDX_W'($urandom_range(nk - 1, 0)), pick_value());
                else if (roll < 72)
                    send_item(FN_WR_B, IDX_W'($urandom_range(nk - 1, 0)),
                              IDX_W'($urandom_range(nc - 1, 0)), pick_value());
                else
                    send_item(FN_EMIT, IDX_W'($urandom_range(nr - 1, 0)),
                              IDX_W'($urandom), VAL_W'($urandom));
            end
        end
        steady <= 1'b0;
    endtask

    // Receiver: random idling, plus a long counted hold when asked for one.
    always @(negedge clk)
    begin
        if (stall_req && stall_cnt < STALL_LEN)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt     <= stall_cnt + 1;
        end
        else
        begin
            if (!stall_req)
                stall_cnt <= 0;
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_c
        c_elem_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (c_expected.size() == 0)
            begin
                fail_count++;
                $display("%0t: result with none expected, expected none actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = c_expected.pop_front();
                flag_field("out_row", want.row, m_axis_tdata[3:0]);
                flag_field("out_col", want.col, m_axis_tdata[7:4]);
                flag_field("product_value", want.prod, m_axis_tdata[43:8]);
                flag_field("row_last", want.last, m_axis_tlast);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, c_expected.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ROWS_A;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FN_WR_A;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_matrices();
        test_extremes();
        test_ignored_items();
        test_zero_sizes();
        test_smallest_sizes();
        test_backpressure();
        test_random();
        settle();

        $display("run covered %0d items in, %0d elements of C checked, %0d size settings",
                 items_sent, results_checked, size_settings);
        $display("including zero and oversized dimensions, extreme values and a long output hold");
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mme_pkg.sv
hw/rtl/mme_ram.sv
hw/rtl/mme_mac_cell.sv
hw/rtl/matrix_multiply_engine_top.sv
verif/tb_top.sv
